FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CHK_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled while in reset.
`define CHK_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: hw/rtl/ffha_pkg.sv
// Types and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int REQ_W   = 17;
  localparam int ADDR_W  = 16;
  localparam int CNT_W   = 17;
  localparam int STAT_W  = 2;
  localparam int unsigned COUNT_MAX = 32'h1FFFF;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] address_res;
    logic [CNT_W-1:0]  free_bytes;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_WALK,
    S_A_WP,
    S_A_WC,
    S_F_HDR,
    S_F_WALK,
    S_F_LINK,
    S_F_JCHK,
    S_F_JEV,
    S_F_WFB,
    S_F_WPREV,
    S_DONE
  } seq_state_t;

endpackage

FILE: hw/rtl/ffha_hdr_mem.sv
// Header store: one write port, one registered read port.
`timescale 1ns / 1ps
module ffha_hdr_mem #(
  parameter int AW = 12,
  parameter int DW = 29
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/ffha_seq.sv
// Sequencer: list walks, split, insert and merge over the header store.
`timescale 1ns / 1ps
module ffha_seq import ffha_pkg::*; #(
  parameter int HEAP_BYTES   = 65536,
  parameter int BLOCK_BYTES  = 64,
  parameter int HEADER_BYTES = 16,
  localparam int HDR_COUNT   = HEAP_BYTES / HEADER_BYTES,
  localparam int AW          = $clog2(HDR_COUNT),
  localparam int SZW         = $clog2(HEAP_BYTES),
  localparam int DW          = 1 + AW + SZW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  in_item_t      in_item,
  output logic          idle,
  output logic          res_valid,
  output out_item_t     res_item,
  input  logic          res_take,
  output logic [AW-1:0] rd_addr,
  input  logic [DW-1:0] rd_data,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [DW-1:0] wr_data
);

  localparam int IW = AW + 1;
  localparam int HS = $clog2(HEADER_BYTES);
  localparam int BS = $clog2(BLOCK_BYTES);
  localparam int RW = REQ_W + 1;
  localparam int NW = ((IW > RW) ? IW : RW) + 1;
  localparam int CW = ((SZW > RW) ? SZW : RW) + 1;
  localparam int FW = ((SZW > CNT_W) ? SZW : CNT_W) + 2;
  localparam logic [IW-1:0] NO_BLK = IW'(HDR_COUNT);
  localparam int unsigned FC_RAW =
    ((HEAP_BYTES - HEADER_BYTES) / BLOCK_BYTES) * BLOCK_BYTES;
  localparam int unsigned FC_INIT = (FC_RAW > COUNT_MAX) ? COUNT_MAX : FC_RAW;

  function automatic logic [IW-1:0] link_of(input logic [AW-1:0] nxt);
    link_of = (nxt == '0) ? NO_BLK : {1'b0, nxt};
  endfunction

  seq_state_t state_r, state_nxt;

  logic [AW-1:0]     clr_r, clr_nxt;
  logic [RW-1:0]     rsize_r, rsize_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     prev_r, prev_nxt;
  logic [IW-1:0]     steps_r, steps_nxt;
  logic [IW-1:0]     tgt_r, tgt_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [SZW-1:0]    csize_r, csize_nxt;
  logic              cw_r, cw_nxt;
  logic [SZW-1:0]    psize_r, psize_nxt;
  logic [AW-1:0]     pnext_r, pnext_nxt;
  logic              pw_r, pw_nxt;
  logic [AW-1:0]     fb_r, fb_nxt;
  logic [SZW-1:0]    fsize_r, fsize_nxt;
  logic [AW-1:0]     fnext_r, fnext_nxt;
  logic [SZW-1:0]    own_r, own_nxt;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ADDR_W-1:0] ares_r, ares_nxt;

  logic              rd_w;
  logic [AW-1:0]     rd_next;
  logic [SZW-1:0]    rd_size;
  logic [IW-1:0]     link_rd;
  logic [RW-1:0]     req_round;
  logic              req_bad;
  logic [ADDR_W-1:0] fbw;
  logic              addr_bad;
  logic              fit;
  logic [CW-1:0]     rem;
  logic [NW-1:0]     nidx;
  logic              split;
  logic              a_stop;
  logic              f_cont;
  logic              hdr_ok;
  logic [IW-1:0]     fj_right;
  logic              fj_ok;
  logic              pj_ok;
  logic [FW-1:0]     taken;
  logic [CNT_W-1:0]  fc_sub;
  logic [FW-1:0]     fc_sum;
  logic [CNT_W-1:0]  fc_add;
  logic [31:0]       pay_off;

  assign rd_w    = rd_data[DW-1];
  assign rd_next = rd_data[DW-2 -: AW];
  assign rd_size = rd_data[SZW-1:0];
  assign link_rd = link_of(rd_next);

  assign req_round = (in_item.request_size[BS-1:0] != '0) ?
    RW'((({1'b0, in_item.request_size} >> BS) + RW'(1)) << BS) :
    {1'b0, in_item.request_size};
  assign req_bad = (in_item.request_size == '0) || (in_item.request_size > fc_r);

  assign fbw      = (in_item.address >> HS) - ADDR_W'(1);
  assign addr_bad = (32'(in_item.address) < 32'(HEADER_BYTES)) ||
                    (in_item.address[HS-1:0] != '0) ||
                    (32'(fbw) >= 32'(HDR_COUNT));

  assign fit    = CW'(rd_size) >= CW'(rsize_r);
  assign rem    = CW'(rd_size) - CW'(rsize_r);
  assign nidx   = NW'(cur_r) + NW'(rsize_r >> HS) + NW'(1);
  assign split  = (rem >= CW'(HEADER_BYTES)) && (nidx < NW'(HDR_COUNT));
  assign a_stop = (cur_r == NO_BLK) || (steps_r == NO_BLK);
  assign f_cont = (cur_r != NO_BLK) && (cur_r < {1'b0, fb_r}) && (steps_r < NO_BLK);
  assign hdr_ok = rd_w && (rd_size != '0) && (rd_size[BS-1:0] == '0) && (rd_next == '0);

  assign fj_right = link_of(fnext_r);
  assign fj_ok    = (steps_r < NO_BLK) && (fj_right != NO_BLK) &&
                    (NW'(fb_r) + NW'(fsize_r >> HS) + NW'(1) == NW'(fj_right));
  assign pj_ok    = (prev_r != NO_BLK) &&
                    (NW'(prev_r) + NW'(psize_r >> HS) + NW'(1) == NW'(fb_r));

  assign taken  = FW'(csize_r) + FW'(HEADER_BYTES);
  assign fc_sub = (taken >= FW'(fc_r)) ? '0 : CNT_W'(FW'(fc_r) - taken);
  assign fc_sum = FW'(fc_r) + FW'(own_r) + FW'(HEADER_BYTES);
  assign fc_add = (fc_sum > FW'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : CNT_W'(fc_sum);
  assign pay_off = (32'(cur_r) + 32'd1) << HS;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (clr_r == AW'(HDR_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.kind == KIND_ALLOC) begin
            state_nxt = req_bad ? S_DONE : S_A_WALK;
          end else begin
            state_nxt = addr_bad ? S_DONE : S_F_HDR;
          end
        end
      end
      S_A_WALK: begin
        if (a_stop) state_nxt = S_DONE;
        else if (fit) state_nxt = S_A_WP;
      end
      S_A_WP:    state_nxt = S_A_WC;
      S_A_WC:    state_nxt = S_DONE;
      S_F_HDR:   state_nxt = hdr_ok ? S_F_WALK : S_DONE;
      S_F_WALK:  if (!f_cont) state_nxt = S_F_LINK;
      S_F_LINK:  state_nxt = S_F_JCHK;
      S_F_JCHK:  state_nxt = fj_ok ? S_F_JEV : S_F_WFB;
      S_F_JEV:   state_nxt = S_F_JCHK;
      S_F_WFB:   state_nxt = S_F_WPREV;
      S_F_WPREV: state_nxt = S_DONE;
      S_DONE:    if (res_take) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    clr_nxt    = clr_r;
    rsize_nxt  = rsize_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    steps_nxt  = steps_r;
    tgt_nxt    = tgt_r;
    head_nxt   = head_r;
    csize_nxt  = csize_r;
    cw_nxt     = cw_r;
    psize_nxt  = psize_r;
    pnext_nxt  = pnext_r;
    pw_nxt     = pw_r;
    fb_nxt     = fb_r;
    fsize_nxt  = fsize_r;
    fnext_nxt  = fnext_r;
    own_nxt    = own_r;
    fc_nxt     = fc_r;
    status_nxt = status_r;
    ares_nxt   = ares_r;
    rd_addr    = cur_r[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    idle       = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = (clr_r == '0) ?
          {1'b1, {AW{1'b0}}, SZW'(HEAP_BYTES - HEADER_BYTES)} : '0;
        clr_nxt = clr_r + AW'(1);
      end
      S_IDLE: begin
        idle      = 1'b1;
        rsize_nxt = req_round;
        cur_nxt   = head_r;
        prev_nxt  = NO_BLK;
        steps_nxt = '0;
        ares_nxt  = '0;
        fb_nxt    = AW'(fbw);
        if (in_item.kind == KIND_ALLOC) begin
          rd_addr    = head_r[AW-1:0];
          status_nxt = ST_FAIL;
        end else begin
          rd_addr    = AW'(fbw);
          status_nxt = ST_BAD_FREE;
        end
      end
      S_A_WALK: begin
        if (!a_stop) begin
          if (fit) begin
            csize_nxt = split ? SZW'(rsize_r) : rd_size;
            cw_nxt    = rd_w;
            tgt_nxt   = split ? IW'(nidx) : link_rd;
            if (split) begin
              wr_en   = 1'b1;
              wr_addr = AW'(nidx);
              wr_data = {1'b1, rd_next, SZW'(rem - CW'(HEADER_BYTES))};
              if (NW'(prev_r) == nidx) begin
                psize_nxt = SZW'(rem - CW'(HEADER_BYTES));
                pnext_nxt = rd_next;
                pw_nxt    = 1'b1;
              end
            end
          end else begin
            prev_nxt  = cur_r;
            psize_nxt = rd_size;
            pnext_nxt = rd_next;
            pw_nxt    = rd_w;
            cur_nxt   = link_rd;
            steps_nxt = steps_r + IW'(1);
            rd_addr   = link_rd[AW-1:0];
          end
        end
      end
      S_A_WP: begin
        if (prev_r == NO_BLK) begin
          head_nxt = tgt_r;
        end else begin
          wr_en   = 1'b1;
          wr_addr = prev_r[AW-1:0];
          wr_data = {pw_r, (tgt_r == NO_BLK) ? {AW{1'b0}} : tgt_r[AW-1:0], psize_r};
        end
      end
      S_A_WC: begin
        wr_en      = 1'b1;
        wr_addr    = cur_r[AW-1:0];
        wr_data    = {cw_r, {AW{1'b0}}, csize_r};
        fc_nxt     = fc_sub;
        status_nxt = ST_OK;
        ares_nxt   = pay_off[ADDR_W-1:0];
      end
      S_F_HDR: begin
        fsize_nxt = rd_size;
        own_nxt   = rd_size;
        rd_addr   = head_r[AW-1:0];
      end
      S_F_WALK: begin
        if (f_cont) begin
          prev_nxt  = cur_r;
          psize_nxt = rd_size;
          pnext_nxt = rd_next;
          pw_nxt    = rd_w;
          cur_nxt   = link_rd;
          steps_nxt = steps_r + IW'(1);
          rd_addr   = link_rd[AW-1:0];
        end
      end
      S_F_LINK: begin
        fnext_nxt = (cur_r == NO_BLK) ? '0 : cur_r[AW-1:0];
        steps_nxt = '0;
        if (prev_r == NO_BLK) begin
          head_nxt = {1'b0, fb_r};
        end else begin
          wr_en     = 1'b1;
          wr_addr   = prev_r[AW-1:0];
          wr_data   = {pw_r, fb_r, psize_r};
          pnext_nxt = fb_r;
        end
      end
      S_F_JCHK: rd_addr = fj_right[AW-1:0];
      S_F_JEV: begin
        fsize_nxt = SZW'(CW'(fsize_r) + CW'(rd_size) + CW'(HEADER_BYTES));
        fnext_nxt = rd_next;
        steps_nxt = steps_r + IW'(1);
      end
      S_F_WFB: begin
        wr_en   = 1'b1;
        wr_addr = fb_r;
        wr_data = {1'b1, fnext_r, fsize_r};
      end
      S_F_WPREV: begin
        if (pj_ok) begin
          wr_en   = 1'b1;
          wr_addr = prev_r[AW-1:0];
          wr_data = {pw_r, fnext_r,
                     SZW'(CW'(psize_r) + CW'(fsize_r) + CW'(HEADER_BYTES))};
        end
        fc_nxt     = fc_add;
        status_nxt = ST_OK;
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res_item = '{status: status_r, address_res: ares_r, free_bytes: fc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      head_r  <= '0;
      fc_r    <= CNT_W'(FC_INIT);
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      head_r  <= head_nxt;
      fc_r    <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsize_r  <= rsize_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    steps_r  <= steps_nxt;
    tgt_r    <= tgt_nxt;
    csize_r  <= csize_nxt;
    cw_r     <= cw_nxt;
    psize_r  <= psize_nxt;
    pnext_r  <= pnext_nxt;
    pw_r     <= pw_nxt;
    fb_r     <= fb_nxt;
    fsize_r  <= fsize_nxt;
    fnext_r  <= fnext_nxt;
    own_r    <= own_nxt;
    status_r <= status_nxt;
    ares_r   <= ares_nxt;
  end

endmodule

FILE: hw/rtl/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator.
//
//  channel  | direction | handshake           | payload
//  in_      | input     | in_valid / in_stall | in_item (kind, request_size, address)
//  out_     | output    | out_valid/out_stall | out_item (status, address_res, free_bytes)
//
// One item at a time. Allocate walks the free list, then writes the link and header.
// Free checks the header, walks to its place, links it, merges right, then left.
// The header store has a single read port, so the walks read one header per step.
// After reset a pass that clears every header holds in_stall high.
// A finished item waits in the output register; the next item is accepted meanwhile.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
  parameter int HEAP_BYTES   = 65536,
  parameter int BLOCK_BYTES  = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW  = $clog2(HEAP_BYTES / HEADER_BYTES);
  localparam int DW  = 1 + AW + $clog2(HEAP_BYTES);

  logic          idle;
  logic          res_valid;
  out_item_t     res_item;
  logic          res_take;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;

  ffha_hdr_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffha_seq #(
    .HEAP_BYTES   (HEAP_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .idle      (idle),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_take  (res_take),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign in_stall = !idle;
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hw/rtl/ffha_checker.sv
// Port checker for the heap allocator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffha_checker import ffha_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  `CHK_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
  `CHK_IMP(a_status_code, clk, rst_n, out_valid, out_item.status != 2'd3)
  `CHK_IMP(a_zero_addr, clk, rst_n, out_valid && out_item.status != ST_OK, out_item.address_res == '0)
  `CHK_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_NXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_item))

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: tb/first_fit_heap_allocator_unit_tb.sv
// Self-checking testbench for the first-fit heap allocator unit.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit_tb;
  import ffha_pkg::*;

  localparam int unsigned HEAP = 65536;
  localparam int unsigned GRAN = 64;
  localparam int unsigned HDR = 16;
  localparam int unsigned HDR_N = HEAP / HDR;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  first_fit_heap_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // Heap shadow
  int unsigned blk_size [HDR_N];
  int unsigned blk_next [HDR_N];
  bit blk_written [HDR_N];
  int unsigned list_head;
  int unsigned bytes_free;

  out_item_t expected_q[$];
  logic [ADDR_W-1:0] live_addrs[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned n_alloc = 0, n_free = 0, n_refused = 0;
  bit calm = 1'b0;

  function automatic int unsigned link_of(int unsigned i);
    int unsigned n;
    n = blk_next[i];
    return (n == 0 || n >= HDR_N) ? HDR_N : n;
  endfunction

  function automatic bit join_right(int unsigned left);
    int unsigned right;
    if (left >= HDR_N) return 1'b0;
    right = link_of(left);
    if (right == HDR_N) return 1'b0;
    if (left * HDR + blk_size[left] + HDR != right * HDR) return 1'b0;
    blk_size[left] += blk_size[right] + HDR;
    blk_next[left] = blk_next[right];
    return 1'b1;
  endfunction

  function automatic void set_link(int unsigned prev, int unsigned target);
    if (prev == HDR_N) list_head = target;
    else blk_next[prev] = (target == HDR_N) ? 0 : target;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < HDR_N; i++) begin
      blk_size[i] = 0;
      blk_next[i] = 0;
      blk_written[i] = 1'b0;
    end
    blk_size[0] = HEAP - HDR;
    blk_written[0] = 1'b1;
    list_head = 0;
    bytes_free = ((HEAP - HDR) / GRAN) * GRAN;
    if (bytes_free > COUNT_MAX) bytes_free = COUNT_MAX;
  endfunction

  function automatic logic [STAT_W-1:0] first_fit(int unsigned req, output int unsigned addr);
    int unsigned sz, cur, prev, steps, rem, nidx, taken;
    sz = req;
    cur = list_head;
    prev = HDR_N;
    steps = 0;
    addr = 0;
    if (sz == 0 || sz > bytes_free) return ST_FAIL;
    if (sz % GRAN) sz = GRAN * (1 + sz / GRAN);
    while (cur != HDR_N && cur < HDR_N && steps < HDR_N) begin
      if (blk_size[cur] >= sz) begin
        rem = blk_size[cur] - sz;
        nidx = cur + (sz + HDR) / HDR;
        if (rem >= HDR && nidx < HDR_N) begin
          blk_size[nidx] = rem - HDR;
          blk_next[nidx] = blk_next[cur];
          blk_written[nidx] = 1'b1;
          set_link(prev, nidx);
          blk_size[cur] = sz;
        end else begin
          set_link(prev, link_of(cur));
        end
        blk_next[cur] = 0;
        taken = blk_size[cur] + HDR;
        bytes_free = (taken >= bytes_free) ? 0 : bytes_free - taken;
        addr = (cur * HDR + HDR) & 16'hFFFF;
        return ST_OK;
      end
      prev = cur;
      cur = link_of(cur);
      steps++;
    end
    return ST_FAIL;
  endfunction

  function automatic logic [STAT_W-1:0] release_block(int unsigned a);
    int unsigned fb, cur, prev, steps, own;
    prev = HDR_N;
    steps = 0;
    if (a < HDR || (a - HDR) % HDR) return ST_BAD_FREE;
    fb = (a - HDR) / HDR;
    if (fb >= HDR_N) return ST_BAD_FREE;
    if (!blk_written[fb] || blk_size[fb] == 0 || blk_size[fb] % GRAN || blk_next[fb] != 0)
      return ST_BAD_FREE;
    own = blk_size[fb];
    cur = list_head;
    while (cur != HDR_N && cur < fb && steps < HDR_N) begin
      prev = cur;
      cur = link_of(cur);
      steps++;
    end
    if (cur >= HDR_N) cur = HDR_N;
    set_link(prev, fb);
    blk_next[fb] = (cur == HDR_N) ? 0 : cur;
    steps = 0;
    while (steps < HDR_N && join_right(fb)) steps++;
    if (prev != HDR_N) void'(join_right(prev));
    bytes_free += own + HDR;
    if (bytes_free > COUNT_MAX || bytes_free < own) bytes_free = COUNT_MAX;
    return ST_OK;
  endfunction

  function automatic out_item_t predict(in_item_t it);
    out_item_t r;
    int unsigned a;
    a = 0;
    if (it.kind == KIND_ALLOC) r.status = first_fit(it.request_size, a);
    else r.status = release_block(it.address);
    r.address_res = (r.status == ST_OK) ? a[ADDR_W-1:0] : '0;
    r.free_bytes = bytes_free[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic kind, input int unsigned req, input int unsigned a);
    in_item_t it;
    out_item_t r;
    it.kind = kind;
    it.request_size = req[REQ_W-1:0];
    it.address = a[ADDR_W-1:0];
    while (!calm && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    do @(posedge clk); while (in_stall);
    r = predict(it);
    expected_q.push_back(r);
    if (kind == KIND_ALLOC) n_alloc++;
    else n_free++;
    if (r.status != ST_OK) n_refused++;
    if (kind == KIND_ALLOC && r.status == ST_OK) live_addrs.push_back(r.address_res);
    @(negedge clk);
  endtask

  task automatic alloc_bytes(input int unsigned req);
    send_item(KIND_ALLOC, req, $urandom);
  endtask

  task automatic free_addr(input int unsigned a);
    send_item(KIND_FREE, $urandom, a);
  endtask

  task automatic free_live(input int idx);
    logic [ADDR_W-1:0] a;
    a = live_addrs[idx];
    live_addrs.delete(idx);
    free_addr(a);
  endtask

  task automatic test_extremes();
    alloc_bytes(0);
    alloc_bytes(65536);
    alloc_bytes(131071);
    alloc_bytes(1);
    alloc_bytes(64);
    alloc_bytes(65);
    alloc_bytes(4000);
    free_live(1);
    free_live(0);
    free_live(1);
    free_live(0);
    alloc_bytes(65472);
    free_live(0);
  endtask

  task automatic test_invalid_frees();
    free_addr(0);
    free_addr(8);
    free_addr(17);
    free_addr(65535);
    free_addr(65520);
    free_addr(4000 * 16 + 16);
    alloc_bytes(48);
    free_addr(live_addrs[0] + 16);
    free_live(0);
    free_addr(16);
  endtask

  task automatic test_random_mix();
    int unsigned sz, a;
    for (int n = 0; n < 1950; n++) begin
      calm = (n >= 800 && n < 1100);
      if (live_addrs.size() == 0 || $urandom_range(99) < 55) begin
        case ($urandom_range(19))
          0: sz = $urandom_range(131071);
          1: sz = $urandom_range(1) ? 0 : 65536;
          2, 3, 4, 5: sz = $urandom_range(4096, 513);
          default: sz = $urandom_range(512, 1);
        endcase
        alloc_bytes(sz);
      end else if ($urandom_range(99) < 85) begin
        free_live($urandom_range(live_addrs.size() - 1));
      end else begin
        do a = $urandom_range(65535); while (a >= HDR && (a - HDR) % HDR == 0);
        free_addr(a);
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_double_free();
    logic [ADDR_W-1:0] a;
    while (live_addrs.size() > 0) free_live(live_addrs.size() - 1);
    alloc_bytes(64);
    alloc_bytes(64);
    a = live_addrs[1];
    free_live(1);
    free_addr(a);
    free_addr(a);
    alloc_bytes(128);
    alloc_bytes(70000);
  endtask

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 21);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", out_item);
      end else begin
        if (out_item.status !== expected_q[0].status ||
            out_item.address_res !== expected_q[0].address_res ||
            out_item.free_bytes !== expected_q[0].free_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", expected_q[0], out_item);
        end
        void'(expected_q.pop_front());
      end
    end
  end

  initial begin
    heap_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_invalid_frees();
    test_random_mix();
    test_double_free();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d allocate and %0d free items, %0d refused,", n_alloc, n_free, n_refused);
    $display("including invalid frees, full-heap requests and a repeated free.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
